// ----- rtl/escaped_frame_command_receiver_unit_macros.svh -----
// Assertion macros for the escaped frame command receiver.
// Included by the top level; no other dependencies.
`ifndef ESCAPED_FRAME_COMMAND_RECEIVER_UNIT_MACROS_SVH
`define ESCAPED_FRAME_COMMAND_RECEIVER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define EFCR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define EFCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define EFCR_ASSERT_IMPL(label, ante, cons, msg)
`define EFCR_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- rtl/efcr_pkg.sv -----
// Shared types, constants and the command code map of the frame receiver.
// No dependencies.
package efcr_pkg;

  // Frame length limits
  localparam int MAX_FRAME_BYTES = 32;
  localparam int COUNT_W         = 6;
  localparam int COUNT_MAX       = (1 << COUNT_W) - 1;
  localparam int CNT_LIMIT       = (MAX_FRAME_BYTES > COUNT_MAX) ? COUNT_MAX : MAX_FRAME_BYTES;
  localparam int KEPT_BYTES      = 10;
  localparam int KEPT_IDX_W      = $clog2(KEPT_BYTES);
  localparam int MIN_FRAME       = 5;
  localparam int CODE_IDX        = 4;

  // Frame byte positions of the arguments
  localparam int ARG1_IDX = 5;
  localparam int ARG2_IDX = 6;
  localparam int ARG3_IDX = 7;
  localparam int DUR_HI_IDX = 8;
  localparam int DUR_LO_IDX = 9;

  // Stream widths
  localparam int IN_DATA_W  = 8;
  localparam int RESULT_W   = 76;
  localparam int OUT_DATA_W = 80;

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [1:0] REG_START  = 2'd0;
  localparam logic [1:0] REG_STOP   = 2'd1;
  localparam logic [1:0] REG_ESCAPE = 2'd2;
  localparam logic [7:0] START_RESET  = 8'd18;
  localparam logic [7:0] STOP_RESET   = 8'd19;
  localparam logic [7:0] ESCAPE_RESET = 8'd125;

  // Command codes as received in frame byte 4
  localparam logic [7:0] CMD_PINMODE     = 8'd2;
  localparam logic [7:0] CMD_DWRITE      = 8'd3;
  localparam logic [7:0] CMD_DREAD       = 8'd4;
  localparam logic [7:0] CMD_AREF        = 8'd6;
  localparam logic [7:0] CMD_AREAD       = 8'd7;
  localparam logic [7:0] CMD_AWRITE      = 8'd9;
  localparam logic [7:0] CMD_TONE        = 8'd10;
  localparam logic [7:0] CMD_NOTONE      = 8'd11;
  localparam logic [7:0] CMD_ATTACH      = 8'd21;
  localparam logic [7:0] CMD_DETACH      = 8'd22;
  localparam logic [7:0] CMD_EEREAD      = 8'd31;
  localparam logic [7:0] CMD_EEWRITE     = 8'd33;
  localparam logic [7:0] CMD_EESYNCWRITE = 8'd34;
  localparam logic [7:0] CMD_PING        = 8'd66;

  // Dense operation numbers
  localparam logic [3:0] OP_PINMODE     = 4'd0;
  localparam logic [3:0] OP_DWRITE      = 4'd1;
  localparam logic [3:0] OP_DREAD       = 4'd2;
  localparam logic [3:0] OP_AREF        = 4'd3;
  localparam logic [3:0] OP_AREAD       = 4'd4;
  localparam logic [3:0] OP_AWRITE      = 4'd5;
  localparam logic [3:0] OP_TONE        = 4'd6;
  localparam logic [3:0] OP_NOTONE      = 4'd7;
  localparam logic [3:0] OP_ATTACH      = 4'd8;
  localparam logic [3:0] OP_DETACH      = 4'd9;
  localparam logic [3:0] OP_EEREAD      = 4'd10;
  localparam logic [3:0] OP_EEWRITE     = 4'd11;
  localparam logic [3:0] OP_EESYNCWRITE = 4'd12;
  localparam logic [3:0] OP_PING        = 4'd13;

  typedef logic [7:0] octet_t;
  typedef logic [KEPT_BYTES-1:0][7:0] frame_t;

  typedef enum logic [1:0] {
    MODE_WAIT = 2'd0,
    MODE_MSG  = 2'd1,
    MODE_ESC  = 2'd2
  } rx_mode_t;

  typedef struct packed {
    octet_t start_marker;
    octet_t stop_marker;
    octet_t escape_marker;
  } markers_t;

  // Result word: operation sits in the lowest bits
  typedef struct packed {
    logic [15:0] duration_word;
    logic [15:0] frequency_word;
    logic [15:0] address_word;
    octet_t      third_arg;
    octet_t      second_arg;
    octet_t      first_arg;
    logic [3:0]  operation;
  } result_t;

  typedef struct packed {
    logic       known;
    logic [3:0] op;
  } op_lookup_t;

  // Output buffer status toward the input stage
  typedef struct packed {
    logic room;
    logic full;
  } buf_status_t;

  // Map a command code to its operation number
  function automatic op_lookup_t map_code(input octet_t code);
    op_lookup_t r;
    r.known = 1'b1;
    case (code)
      CMD_PINMODE:     r.op = OP_PINMODE;
      CMD_DWRITE:      r.op = OP_DWRITE;
      CMD_DREAD:       r.op = OP_DREAD;
      CMD_AREF:        r.op = OP_AREF;
      CMD_AREAD:       r.op = OP_AREAD;
      CMD_AWRITE:      r.op = OP_AWRITE;
      CMD_TONE:        r.op = OP_TONE;
      CMD_NOTONE:      r.op = OP_NOTONE;
      CMD_ATTACH:      r.op = OP_ATTACH;
      CMD_DETACH:      r.op = OP_DETACH;
      CMD_EEREAD:      r.op = OP_EEREAD;
      CMD_EEWRITE:     r.op = OP_EEWRITE;
      CMD_EESYNCWRITE: r.op = OP_EESYNCWRITE;
      CMD_PING:        r.op = OP_PING;
      default: begin
        r.known = 1'b0;
        r.op    = OP_PINMODE;
      end
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/efcr_cfg_regs.sv -----
// Marker registers behind the APB-style configuration port.
// Depends on efcr_pkg.
module efcr_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [efcr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [efcr_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [efcr_pkg::CFG_DATA_W-1:0]  prdata,
  output efcr_pkg::markers_t               markers
);
  import efcr_pkg::*;

  logic       wr_en;
  logic [1:0] reg_sel;

  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  // Write the selected marker; addresses past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      markers.start_marker  <= START_RESET;
      markers.stop_marker   <= STOP_RESET;
      markers.escape_marker <= ESCAPE_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_START:  markers.start_marker  <= pwdata[7:0];
        REG_STOP:   markers.stop_marker   <= pwdata[7:0];
        REG_ESCAPE: markers.escape_marker <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      REG_START:  prdata = {{(CFG_DATA_W-8){1'b0}}, markers.start_marker};
      REG_STOP:   prdata = {{(CFG_DATA_W-8){1'b0}}, markers.stop_marker};
      REG_ESCAPE: prdata = {{(CFG_DATA_W-8){1'b0}}, markers.escape_marker};
      default:    prdata = '0;
    endcase
  end

endmodule

// ----- rtl/efcr_cmd_decode.sv -----
// Command decode of a stored frame: operation lookup and argument fields.
// Depends on efcr_pkg.
module efcr_cmd_decode (
  input  efcr_pkg::frame_t   frame_bytes,
  output logic               known,
  output efcr_pkg::result_t  result
);
  import efcr_pkg::*;

  op_lookup_t lookup;

  assign lookup = map_code(frame_bytes[CODE_IDX]);
  assign known  = lookup.known;

  // Assemble every field regardless of which ones the operation uses
  always_comb begin
    result.operation      = lookup.op;
    result.first_arg      = frame_bytes[ARG1_IDX];
    result.second_arg     = frame_bytes[ARG2_IDX];
    result.third_arg      = frame_bytes[ARG3_IDX];
    result.address_word   = {frame_bytes[ARG1_IDX], frame_bytes[ARG2_IDX]};
    result.frequency_word = {frame_bytes[ARG2_IDX], frame_bytes[ARG3_IDX]};
    result.duration_word  = {frame_bytes[DUR_HI_IDX], frame_bytes[DUR_LO_IDX]};
  end

endmodule

// ----- rtl/efcr_deframer.sv -----
// Byte-stuffing deframer: mode machine, byte count and frame byte store.
// Depends on efcr_pkg and efcr_cmd_decode.
module efcr_deframer (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  efcr_pkg::octet_t    rx_byte,
  input  efcr_pkg::markers_t  markers,
  output logic                res_valid,
  output efcr_pkg::result_t   result
);
  import efcr_pkg::*;

  rx_mode_t             mode;
  rx_mode_t             mode_next;
  logic [COUNT_W-1:0]   byte_count;
  logic [COUNT_W-1:0]   byte_count_next;
  frame_t               frame_bytes;
  logic                 store;
  logic                 stop_hit;
  logic                 known;

  efcr_cmd_decode u_decode (
    .frame_bytes (frame_bytes),
    .known       (known),
    .result      (result)
  );

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_WAIT;
    end else if (advance) begin
      mode <= mode_next;
    end
  end

  // Next mode, count and store decision for the word in hand
  always_comb begin
    mode_next       = mode;
    byte_count_next = byte_count;
    store           = 1'b0;
    stop_hit        = 1'b0;
    case (mode)
      MODE_MSG: begin
        if (rx_byte == markers.escape_marker) begin
          mode_next = MODE_ESC;
        end else if (rx_byte == markers.stop_marker) begin
          stop_hit  = 1'b1;
          mode_next = MODE_WAIT;
        end else if (rx_byte == markers.start_marker) begin
          byte_count_next = '0;
        end else begin
          store = 1'b1;
        end
      end
      MODE_ESC: begin
        store     = 1'b1;
        mode_next = MODE_MSG;
      end
      default: begin
        mode_next = MODE_WAIT;
        if (rx_byte == markers.start_marker) begin
          mode_next       = MODE_MSG;
          byte_count_next = '0;
        end
      end
    endcase
    // Saturate the count
    if (store && (byte_count < COUNT_W'(CNT_LIMIT))) begin
      byte_count_next = byte_count + COUNT_W'(1);
    end
  end

  // Emit on stop when the frame is long enough and the code is known
  assign res_valid = advance && stop_hit && known &&
                     (byte_count >= COUNT_W'(MIN_FRAME));

  // Byte count
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (advance) begin
      byte_count <= byte_count_next;
    end
  end

  // Keep only the first frame bytes; later ones are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_bytes <= '0;
    end else if (advance && store && (byte_count < COUNT_W'(KEPT_BYTES))) begin
      frame_bytes[byte_count[KEPT_IDX_W-1:0]] <= rx_byte;
    end
  end

endmodule

// ----- rtl/efcr_out_buf.sv -----
// Two-entry result buffer driving the master stream side.
// Depends on efcr_pkg.
module efcr_out_buf (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  efcr_pkg::result_t          push_data,
  output efcr_pkg::buf_status_t      status,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [efcr_pkg::OUT_DATA_W-1:0] m_tdata
);
  import efcr_pkg::*;

  result_t    slot0;
  result_t    slot1;
  logic [1:0] fill;
  logic [1:0] fill_next;
  logic       pop;
  logic [1:0] base;

  assign pop       = m_tvalid && m_tready;
  assign m_tvalid  = (fill != 2'd0);
  assign m_tdata   = {{(OUT_DATA_W-RESULT_W){1'b0}}, slot0};
  assign status.room = (fill != 2'd2);
  assign status.full = (fill == 2'd2);

  // Slot the next push lands in after any pop this cycle
  assign base      = fill - {1'b0, pop};
  assign fill_next = base + {1'b0, push};

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      fill <= fill_next;
    end
  end

  // Place the new word in the head slot, else shift forward on pop
  always_ff @(posedge clk) begin
    if (push && (base == 2'd0)) begin
      slot0 <= push_data;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

  // Place the new word behind the head
  always_ff @(posedge clk) begin
    if (push && (base != 2'd0)) begin
      slot1 <= push_data;
    end
  end

endmodule

// ----- rtl/escaped_frame_command_receiver_unit.sv -----
// Channel   Dir  Signals                          Word
// s_*       in   s_tvalid s_tready s_tdata[7:0]   one received byte
// m_*       out  m_tvalid m_tready m_tdata[79:0]  one decoded command
// apb       in   psel penable pwrite paddr pwdata marker registers at 0x0, 0x4, 0x8
//
// One byte per cycle while the output buffer has a free slot; a byte waits in the input
// register, and the deframer writes any result into the output buffer at the edge it leaves.
// The two-entry output buffer lets input flow on while a result waits.
// Synchronous active-high reset clears mode, count, frame store and buffers.
// Top level; depends on efcr_pkg, efcr_cfg_regs, efcr_deframer, efcr_out_buf.
`include "escaped_frame_command_receiver_unit_macros.svh"
module escaped_frame_command_receiver_unit (
  input  logic                              clk,
  input  logic                              rst,
  // rx_byte[7:0]
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [efcr_pkg::IN_DATA_W-1:0]    s_tdata,
  // operation[3:0] first_arg[11:4] second_arg[19:12] third_arg[27:20]
  // address_word[43:28] frequency_word[59:44] duration_word[75:60] zero[79:76]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [efcr_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [efcr_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [efcr_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [efcr_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import efcr_pkg::*;

  markers_t    markers;
  logic        in_valid;
  octet_t      in_byte;
  logic        advance;
  logic        res_valid;
  result_t     result;
  buf_status_t buf_status;

  assign pready = 1'b1;

  efcr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .markers (markers)
  );

  // Input register advances whenever the buffer has a free slot
  assign advance  = in_valid && buf_status.room;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  efcr_deframer u_deframer (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .rx_byte   (in_byte),
    .markers   (markers),
    .res_valid (res_valid),
    .result    (result)
  );

  efcr_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (result),
    .status    (buf_status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // A result never lands in a full buffer
  `EFCR_ASSERT_IMPL(a_no_push_full, res_valid, !buf_status.full, "result pushed into full buffer")
  // Decoded operation numbers stay within the defined range
  `EFCR_ASSERT_IMPL(a_op_range, res_valid, result.operation <= OP_PING, "operation out of range")
  // A held input byte keeps its value while the buffer is full
  `EFCR_ASSERT_NEXT(a_in_hold, in_valid && !advance, in_valid && $stable(in_byte), "input byte lost")

endmodule
